@@ src/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer: operation codes,
// lane count, per-item byte limit and the merge control word.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int C_LANES = 8;
    localparam logic [3:0] C_MAX_BYTES = 4'd8;

    typedef enum logic [2:0] {
        M_ENQ  = 3'd0,
        M_DEQ  = 3'd1,
        M_PEEK = 3'd2,
        M_MVF  = 3'd3,
        M_MVR  = 3'd4,
        M_CLR  = 3'd5,
        M_STAT = 3'd6
    } t_mode;

    typedef logic [C_LANES-1:0][7:0] t_bytes;

    typedef struct packed {
        logic       clr;
        logic       cap0;
        logic       cap1;
        logic [2:0] base_lo;
        logic [3:0] kk;
        logic [3:0] cnt;
    } t_mrg_ctl;

endpackage

@@ src/brb_lane.sv @@
// ----------------------------------------------------------------------------
// brb_lane
// One byte bank of the ring store: slots whose index is congruent to this
// lane's number modulo eight. Single address port, registered read data.
// ----------------------------------------------------------------------------
module brb_lane #(
    parameter int RW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [RW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [0:(1<<RW)-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/brb_merge.sv @@
// ----------------------------------------------------------------------------
// brb_merge
// Gathers the bytes that the lanes return in the two access passes into
// one read word, first byte in the low bits, unused bytes zero.
// ----------------------------------------------------------------------------
module brb_merge
    import brb_pkg::*;
(
    input  logic     i_clk,
    input  t_mrg_ctl i_ctl,
    input  t_bytes   i_lane_data,
    output t_bytes   o_word
);

    t_bytes r_acc;
    t_bytes n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else begin
            for (int i = 0; i < C_LANES; i++) begin
                if (i_ctl.cap0 && (4'(i) < i_ctl.cnt) && (4'(i) < i_ctl.kk)) begin
                    n_acc[i] = i_lane_data[3'(i_ctl.base_lo + 3'(i))];
                end
                if (i_ctl.cap1 && (4'(i) >= i_ctl.kk) && (4'(i) < i_ctl.cnt)) begin
                    n_acc[i] = i_lane_data[3'(4'(i) - i_ctl.kk)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_word = r_acc;

endmodule

@@ src/byte_ring_buffer_fifo_top.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_top
// Byte ring buffer of DEPTH slots holding up to DEPTH-1 bytes, stored in
// eight byte lanes interleaved by slot index.
//
// Input channel: i_valid / o_stall carry one command word (mode, byte
// count, payload, move amount). Output channel: o_valid / i_stall carry one
// result word per command (ok, read bytes, occupancy, runs, pointers).
// From acceptance to the result register each command passes through the
// plan step, two lane access passes (bytes before and after the wrap point),
// merge with pointer update, and result load. A new command is accepted
// only once the previous one has left the result load stage; o_stall
// stays high through every stage of the sequential state machine. A
// result waiting under i_stall does not block the next command, which only
// holds in its last stage until the result register frees up.
// After reset the block sweeps every lane row to zero, one row per cycle,
// with o_stall high; both pointers start at zero.
// ----------------------------------------------------------------------------
module byte_ring_buffer_fifo_top
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_payload,
    input  logic [10:0] i_move_amount,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [63:0] o_read_bytes,
    output logic [9:0]  o_used_count,
    output logic [9:0]  o_free_count,
    output logic [9:0]  o_direct_enqueue_run,
    output logic [9:0]  o_direct_dequeue_run,
    output logic [9:0]  o_front_position,
    output logic [9:0]  o_rear_position
);

    localparam int PW = $clog2(DEPTH);
    localparam int RW = PW - 3;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [PW:0] DEPTH_W = (PW+1)'(DEPTH);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PLAN  = 7'b0000100,
        S_P0    = 7'b0001000,
        S_P1    = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] used_of(input logic [PW-1:0] f,
                                              input logic [PW-1:0] r);
        logic [PW:0] s;
        s = {1'b0, r} - {1'b0, f};
        if (r < f) begin
            s = s + DEPTH_W;
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [9:0] to10(input logic [PW-1:0] v);
        logic [PW+9:0] w;
        w = {10'b0, v};
        return w[9:0];
    endfunction

    t_state r_state, n_state;
    logic [RW-1:0] r_clr_row;

    logic [2:0]  r_mode;
    logic [3:0]  r_cnt;
    logic [63:0] r_payload;
    logic [10:0] r_amount;

    logic [PW-1:0] r_front, r_rear;
    logic [PW-1:0] n_front, n_rear;

    logic          r_ok, r_do_wr, r_do_rd;
    logic [PW-1:0] r_base;
    logic [3:0]    r_kk;

    logic          p_ok, p_do_wr, p_do_rd;
    logic [PW-1:0] p_used, p_free, p_ptr, p_base;
    logic [PW:0]   p_gap;
    logic [3:0]    p_kk;
    logic [PW+3:0] p_cnt_w;
    logic [PW+10:0] p_amt_w;
    logic          p_amt_ok, p_cnt_ok;

    logic [C_LANES-1:0] lane_we;
    logic [RW-1:0]      lane_addr [C_LANES];
    t_bytes             lane_wdata, lane_rdata;
    t_mrg_ctl           mrg_ctl;
    t_bytes             mrg_word;

    logic          out_load;
    logic          r_o_valid;
    logic          r_o_ok;
    logic [63:0]   r_o_read;
    logic [PW-1:0] r_o_used, r_o_free, r_o_erun, r_o_drun, r_o_front, r_o_rear;

    function automatic logic [PW-1:0] r_amount_p();
        logic [PW+10:0] w;
        w = {{PW{1'b0}}, r_amount};
        return w[PW-1:0];
    endfunction

    assign o_stall = (r_state != S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_o_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr_row) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_PLAN;
            S_PLAN:  n_state = S_P0;
            S_P0:    n_state = S_P1;
            S_P1:    n_state = S_UPD;
            S_UPD:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_mode    <= i_mode;
            r_cnt     <= i_byte_count;
            r_payload <= i_payload;
            r_amount  <= i_move_amount;
        end
    end

    always_comb begin
        p_used   = used_of(r_front, r_rear);
        p_free   = LAST - p_used;
        p_cnt_w  = {{PW{1'b0}}, r_cnt};
        p_amt_w  = {{PW{1'b0}}, r_amount};
        p_cnt_ok = (r_cnt <= C_MAX_BYTES);
        p_amt_ok = (p_amt_w <= {11'b0, LAST});
        p_ok     = 1'b0;
        p_do_wr  = 1'b0;
        p_do_rd  = 1'b0;
        unique case (t_mode'(r_mode))
            M_ENQ: begin
                p_ok    = p_cnt_ok && (p_cnt_w <= {4'b0, p_free});
                p_do_wr = p_ok;
            end
            M_DEQ, M_PEEK: begin
                p_ok    = p_cnt_ok && (p_cnt_w <= {4'b0, p_used});
                p_do_rd = p_ok;
            end
            M_MVF, M_MVR: p_ok = p_amt_ok;
            M_CLR, M_STAT: p_ok = 1'b1;
            default: p_ok = 1'b0;
        endcase
        p_ptr  = (t_mode'(r_mode) == M_ENQ) ? r_rear : r_front;
        p_base = (p_ptr == LAST) ? '0 : p_ptr + PW'(1);
        p_gap  = DEPTH_W - {1'b0, p_base};
        p_kk   = (p_gap > (PW+1)'(8)) ? 4'd8 : p_gap[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PLAN) begin
            r_ok    <= p_ok;
            r_do_wr <= p_do_wr;
            r_do_rd <= p_do_rd;
            r_base  <= p_base;
            r_kk    <= p_kk;
        end
    end

    always_comb begin
        logic [2:0]    ib;
        logic [3:0]    j;
        logic [PW-1:0] a0;
        logic          en0, en1;
        for (int b = 0; b < C_LANES; b++) begin
            ib  = 3'(3'(b) - r_base[2:0]);
            j   = r_kk + 4'(b);
            a0  = r_base + PW'(ib);
            en0 = ({1'b0, ib} < r_cnt) && ({1'b0, ib} < r_kk);
            en1 = (j < r_cnt);
            if (r_state == S_CLEAR) begin
                lane_we[b]    = 1'b1;
                lane_addr[b]  = r_clr_row;
                lane_wdata[b] = 8'h00;
            end else if (r_state == S_P1) begin
                lane_we[b]    = r_do_wr && en1;
                lane_addr[b]  = '0;
                lane_wdata[b] = r_payload[8*j[2:0] +: 8];
            end else begin
                lane_we[b]    = (r_state == S_P0) && r_do_wr && en0;
                lane_addr[b]  = a0[PW-1:3];
                lane_wdata[b] = r_payload[8*ib +: 8];
            end
        end
    end

    for (genvar g = 0; g < C_LANES; g++) begin : g_lane
        brb_lane #(
            .RW(RW)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_addr  (lane_addr[g]),
            .i_wdata (lane_wdata[g]),
            .o_rdata (lane_rdata[g])
        );
    end

    always_comb begin
        mrg_ctl.clr     = (r_state == S_PLAN);
        mrg_ctl.cap0    = (r_state == S_P1) && r_do_rd;
        mrg_ctl.cap1    = (r_state == S_UPD) && r_do_rd;
        mrg_ctl.base_lo = r_base[2:0];
        mrg_ctl.kk      = r_kk;
        mrg_ctl.cnt     = r_cnt;
    end

    brb_merge u_merge (
        .i_clk       (i_clk),
        .i_ctl       (mrg_ctl),
        .i_lane_data (lane_rdata),
        .o_word      (mrg_word)
    );

    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        if (r_ok) begin
            unique case (t_mode'(r_mode))
                M_ENQ:  n_rear  = wrap_add(r_rear, PW'(r_cnt));
                M_DEQ:  n_front = wrap_add(r_front, PW'(r_cnt));
                M_MVF:  n_front = wrap_add(r_front, r_amount_p());
                M_MVR:  n_rear  = wrap_add(r_rear, r_amount_p());
                M_CLR: begin
                    n_front = '0;
                    n_rear  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
        end else if (r_state == S_UPD) begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_ok    <= r_ok;
            r_o_read  <= mrg_word;
            r_o_used  <= used_of(r_front, r_rear);
            r_o_free  <= LAST - used_of(r_front, r_rear);
            r_o_erun  <= (r_front > r_rear) ? r_front - r_rear - PW'(1) : LAST - r_rear;
            r_o_drun  <= (r_rear >= r_front) ? r_rear - r_front : LAST - r_front;
            r_o_front <= r_front;
            r_o_rear  <= r_rear;
        end
    end

    assign o_valid              = r_o_valid;
    assign o_ok                 = r_o_ok;
    assign o_read_bytes         = r_o_read;
    assign o_used_count         = to10(r_o_used);
    assign o_free_count         = to10(r_o_free);
    assign o_direct_enqueue_run = to10(r_o_erun);
    assign o_direct_dequeue_run = to10(r_o_drun);
    assign o_front_position     = to10(r_o_front);
    assign o_rear_position      = to10(r_o_rear);

endmodule
